/* rtl/wola_pkg.sv */
`timescale 1ns / 1ps
package wola_pkg;

    // default frame length
    localparam int FRAME_LEN_DEF = 512;

    // field and storage widths
    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = 16;
    localparam int WIN_W    = 16;
    localparam int SUM_W    = 58;
    localparam int WT_W     = 40;
    localparam int PROD_W   = 48;
    localparam int HOP_W    = 10;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_LENGTH  = 1'd1;
    localparam logic             WTYPE_RESET = 1'b1;
    localparam logic [HOP_W-1:0] HOP_RESET   = 10'd256;

    // window constants, q30 and q15
    localparam logic [63:0] Q30_ONE   = 64'd1073741824;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] WIN_A_Q30 = 64'd85899346;
    localparam logic [63:0] WIN_B_Q30 = 64'd987842478;
    localparam logic [63:0] HALF_Q15  = 64'd16384;
    localparam logic [WIN_W-1:0] W_ONE_Q15 = 16'h8000;

    // quotient: 16 magnitude bits, sum scaled by 2^7
    localparam int QBITS      = 16;
    localparam int FRAC_SHIFT = 7;
    localparam int HI_SHIFT   = QBITS - FRAC_SHIFT;
    localparam int CNT_W      = $clog2(QBITS);

    localparam logic [OUT_W-1:0] OUT_MAX   = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_MIN   = 16'h8000;
    localparam logic [QBITS:0]   POS_LIMIT = 17'd32767;
    localparam logic [QBITS:0]   NEG_LIMIT = 17'd32768;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] sample;
        logic             clipped;
    } div_res_t;

endpackage

/* rtl/weighted_overlap_add_synthesis_core.sv */
`timescale 1ns / 1ps
// weighted overlap-add synthesis, one frame sample per item
// an item that finishes no ring position runs multiply, multiply, accumulate, write back;
// an emitting item then runs the 16-step divider, cut short on zero weight or a
// quotient of 2^16 or more; its result shows on m_axis in the cycle that ready returns
// rst_n clears control state and starts a pass that zeroes both rings;
// no item is accepted during the pass, configuration writes are taken at any time
module weighted_overlap_add_synthesis_core #(
    parameter int FRAME_LEN = wola_pkg::FRAME_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration: index 0 window select, index 1 hop_length
    input  logic                            cfg_wen,
    input  logic [wola_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wola_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // frame samples in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wola_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] frame_sample
    input  logic                            s_axis_tlast,  // final_frame

    // reconstructed samples out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wola_pkg::OUT_W-1:0]      m_axis_tdata,  // [15:0] out_sample
    output logic                            m_axis_tuser,  // [0] clipped
    output logic                            m_axis_tlast   // utterance_end
);

    localparam int PW = $clog2(FRAME_LEN);
    localparam int HW = (PW + 1 > wola_pkg::HOP_W) ? PW + 1 : wola_pkg::HOP_W;
    localparam int SW = wola_pkg::SUM_W;
    localparam int DW = wola_pkg::WT_W;
    localparam int XW = wola_pkg::SAMPLE_W;
    localparam int WW = wola_pkg::WIN_W;
    localparam int RW = wola_pkg::PROD_W;

    // sequencer: clear pass, then per item multiply twice, accumulate,
    // write back, and divide and output when the position is final
    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_MULX  = 8'b00000100,
        ST_MULW  = 8'b00001000,
        ST_ACC   = 8'b00010000,
        ST_WB    = 8'b00100000,
        ST_DIV   = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;

    // configuration registers
    logic                       win_sel_reg;
    logic [wola_pkg::HOP_W-1:0] hop_reg;

    // frame tracking
    logic [PW-1:0]              base_reg;
    logic [PW-1:0]              base_next;
    logic [PW-1:0]              fp_reg;
    logic [PW-1:0]              fp_next;
    logic [PW-1:0]              clr_cnt_reg;

    // per-item payload
    logic [XW-1:0]              x_reg;
    logic [PW-1:0]              idx_reg;
    logic                       emit_reg;
    logic                       uend_reg;
    logic signed [RW-1:0]       prod_reg;
    logic [SW-1:0]              sum_acc_reg;
    logic [DW-1:0]              wt_acc_reg;

    // output register
    logic                       out_valid_reg;
    logic [wola_pkg::OUT_W-1:0] out_sample_reg;
    logic                       out_clipped_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       out_load;
    logic [HW-1:0]              hop_ext;
    logic [HW-1:0]              frame_len_h;
    logic [HW-1:0]              eff_hop;
    logic [PW:0]                idx_sum;
    logic [PW-1:0]              idx;
    logic [HW:0]                base_sum;
    logic                       last_pos;
    logic                       emit;

    logic [WW-1:0]              rom_win;
    logic [WW-1:0]              win;
    logic [SW-1:0]              sum_rd;
    logic [DW-1:0]              wt_rd;
    logic                       ring_wen;
    logic [PW-1:0]              ring_waddr;
    logic [SW-1:0]              ring_sum_wr;
    logic [DW-1:0]              ring_wt_wr;

    // shared multiplier: sample times window, then window squared
    logic signed [XW:0]         mul_a;
    logic signed [WW:0]         mul_b;
    logic signed [XW+WW+1:0]    mul_p;

    wola_pkg::div_res_t         div_res;
    logic                       div_start;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // a hop of zero acts as one, a hop past the frame acts as the frame length
    assign hop_ext     = HW'(hop_reg);
    assign frame_len_h = HW'(FRAME_LEN);

    always_comb
    begin
        if (hop_reg == '0)
        begin
            eff_hop = HW'(1);
        end
        else if (hop_ext > frame_len_h)
        begin
            eff_hop = frame_len_h;
        end
        else
        begin
            eff_hop = hop_ext;
        end
    end

    // ring slot of the current place, modulo the frame length
    assign idx_sum  = {1'b0, base_reg} + {1'b0, fp_reg};
    assign idx      = (idx_sum >= (PW+1)'(FRAME_LEN)) ? PW'(idx_sum - (PW+1)'(FRAME_LEN))
                                                      : idx_sum[PW-1:0];
    assign last_pos = ({1'b0, fp_reg} == (PW+1)'(FRAME_LEN - 1));

    // a place is final when it lies before the hop or the frame is the last one
    assign emit     = s_axis_tlast || (HW'(fp_reg) < eff_hop);

    // next frame start moves by the hop, or back to zero after the last frame
    assign base_sum = (HW+1)'(base_reg) + {1'b0, eff_hop};

    always_comb
    begin
        base_next = base_reg;
        fp_next   = fp_reg + PW'(1);
        if (last_pos)
        begin
            fp_next = '0;
            if (s_axis_tlast)
            begin
                base_next = '0;
            end
            else if (base_sum >= (HW+1)'(FRAME_LEN))
            begin
                base_next = PW'(base_sum - (HW+1)'(FRAME_LEN));
            end
            else
            begin
                base_next = base_sum[PW-1:0];
            end
        end
    end

    assign win = win_sel_reg ? rom_win : wola_pkg::W_ONE_Q15;

    always_comb
    begin
        case (state_reg)
            ST_MULX:
            begin
                mul_a = $signed(x_reg[XW-1] ? {1'b1, x_reg} : {1'b0, x_reg});
                mul_b = $signed({1'b0, win});
            end
            default:
            begin
                mul_a = $signed({{(XW + 1 - WW){1'b0}}, win});
                mul_b = $signed({1'b0, win});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if ({1'b0, clr_cnt_reg} == (PW+1)'(FRAME_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                state_next = ST_MULW;
            end
            ST_MULW:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            base_reg      <= '0;
            fp_reg        <= '0;
            win_sel_reg   <= wola_pkg::WTYPE_RESET;
            hop_reg       <= wola_pkg::HOP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + PW'(1);
            end
            if (cfg_wen)
            begin
                case (cfg_addr)
                    wola_pkg::REG_WINDOW_TYPE:
                    begin
                        win_sel_reg <= cfg_wdata[0];
                    end
                    wola_pkg::REG_HOP_LENGTH:
                    begin
                        hop_reg <= cfg_wdata[wola_pkg::HOP_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                base_reg <= base_next;
                fp_reg   <= fp_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= s_axis_tdata;
            idx_reg  <= idx;
            emit_reg <= emit;
            uend_reg <= s_axis_tlast && last_pos;
        end
        case (state_reg)
            ST_MULX:
            begin
                prod_reg <= mul_p[RW-1:0];
            end
            ST_MULW:
            begin
                sum_acc_reg <= sum_rd + {{(SW - RW){prod_reg[RW-1]}}, prod_reg};
                prod_reg    <= mul_p[RW-1:0];
            end
            ST_ACC:
            begin
                wt_acc_reg <= wt_rd + {{(DW - 2 * WW + 1){1'b0}}, prod_reg[2*WW-2:0]};
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_sample_reg  <= div_res.sample;
            out_clipped_reg <= div_res.clipped;
            out_last_reg    <= uend_reg;
        end
    end

    // ring write: zero during the clear pass and on an emit, the new sums otherwise
    assign ring_wen    = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
    assign ring_waddr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;
    assign ring_sum_wr = ((state_reg == ST_CLEAR) || emit_reg) ? '0 : sum_acc_reg;
    assign ring_wt_wr  = ((state_reg == ST_CLEAR) || emit_reg) ? '0 : wt_acc_reg;
    assign div_start   = (state_reg == ST_WB) && emit_reg;

    wola_window_rom #(
        .FRAME_LEN (FRAME_LEN)
    ) u_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (fp_reg),
        .win   (rom_win)
    );

    wola_ring #(
        .FRAME_LEN (FRAME_LEN)
    ) u_ring (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (idx),
        .sum_rd  (sum_rd),
        .wt_rd   (wt_rd),
        .wr_en   (ring_wen),
        .wr_addr (ring_waddr),
        .sum_wr  (ring_sum_wr),
        .wt_wr   (ring_wt_wr)
    );

    wola_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_acc_reg),
        .den   (wt_acc_reg),
        .res   (div_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_clipped_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/wola_window_rom.sv */
`timescale 1ns / 1ps
module wola_window_rom #(
    parameter int FRAME_LEN = wola_pkg::FRAME_LEN_DEF,
    localparam int AW = $clog2(FRAME_LEN)
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             addr,
    output logic [wola_pkg::WIN_W-1:0] win
);

    localparam logic [63:0] N1 = 64'(FRAME_LEN - 1);

    typedef logic [wola_pkg::WIN_W-1:0] rom_t [FRAME_LEN];

    // hamming window in q15, sine from a truncated taylor series in q30
    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] j;
        logic [63:0] phi;
        logic [63:0] p2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] w;
        for (int i = 0; i < FRAME_LEN; i++) begin
            j   = (64'(2 * i) > N1) ? N1 - 64'(i) : 64'(i);
            phi = (j * wola_pkg::PI_Q30) / N1;
            p2  = (phi * phi) >> 30;
            t   = wola_pkg::Q30_ONE - p2 / 64'd110;
            t   = wola_pkg::Q30_ONE - ((p2 * t) >> 30) / 64'd72;
            t   = wola_pkg::Q30_ONE - ((p2 * t) >> 30) / 64'd42;
            t   = wola_pkg::Q30_ONE - ((p2 * t) >> 30) / 64'd20;
            t   = wola_pkg::Q30_ONE - ((p2 * t) >> 30) / 64'd6;
            s   = (phi * t) >> 30;
            s2  = (s * s) >> 30;
            w   = (wola_pkg::WIN_A_Q30 + ((wola_pkg::WIN_B_Q30 * s2) >> 30)
                  + wola_pkg::HALF_Q15) >> 15;
            tab[i] = (w > 64'(wola_pkg::W_ONE_Q15)) ? wola_pkg::W_ONE_Q15
                                                    : w[wola_pkg::WIN_W-1:0];
        end
        return tab;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [wola_pkg::WIN_W-1:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            win_reg <= ROM[addr];
        end
    end

    assign win = win_reg;

endmodule

/* rtl/wola_ring.sv */
`timescale 1ns / 1ps
module wola_ring #(
    parameter int FRAME_LEN = wola_pkg::FRAME_LEN_DEF,
    localparam int AW = $clog2(FRAME_LEN)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [wola_pkg::SUM_W-1:0] sum_rd,
    output logic [wola_pkg::WT_W-1:0]  wt_rd,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [wola_pkg::SUM_W-1:0] sum_wr,
    input  logic [wola_pkg::WT_W-1:0]  wt_wr
);

    logic [wola_pkg::SUM_W-1:0] sum_mem [FRAME_LEN];
    logic [wola_pkg::WT_W-1:0]  wt_mem  [FRAME_LEN];
    logic [wola_pkg::SUM_W-1:0] sum_rd_reg;
    logic [wola_pkg::WT_W-1:0]  wt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sum_mem[wr_addr] <= sum_wr;
            wt_mem[wr_addr]  <= wt_wr;
        end
        if (rd_en)
        begin
            sum_rd_reg <= sum_mem[rd_addr];
            wt_rd_reg  <= wt_mem[rd_addr];
        end
    end

    assign sum_rd = sum_rd_reg;
    assign wt_rd  = wt_rd_reg;

endmodule

/* rtl/wola_div.sv */
`timescale 1ns / 1ps
module wola_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wola_pkg::SUM_W-1:0] sum,
    input  logic [wola_pkg::WT_W-1:0]  den,
    output wola_pkg::div_res_t         res
);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CHECK = 4'b0010,
        D_STEP  = 4'b0100,
        D_DONE  = 4'b1000
    } dstate_t;

    localparam int SW = wola_pkg::SUM_W;
    localparam int DW = wola_pkg::WT_W;
    localparam int QB = wola_pkg::QBITS;
    localparam int HS = wola_pkg::HI_SHIFT;

    dstate_t                  dstate_reg;
    dstate_t                  dstate_next;
    logic [wola_pkg::CNT_W-1:0] cnt_reg;
    logic                     neg_reg;
    logic [SW-1:0]            mag_reg;
    logic [DW-1:0]            den_reg;
    logic [DW-1:0]            rem_reg;
    logic [QB-1:0]            lo_reg;
    logic [QB-1:0]            q_reg;
    logic                     done_reg;
    logic [wola_pkg::OUT_W-1:0] sample_reg;
    logic                     clipped_reg;

    logic [SW-HS-1:0]         hi_part;
    logic                     den_zero;
    logic                     overflow;
    logic [DW+1:0]            trial;
    logic                     qbit;
    logic [DW-1:0]            rem_step;
    logic [QB:0]              tmag;

    assign hi_part  = mag_reg[SW-1:HS];
    assign den_zero = (den_reg == '0);
    assign overflow = (hi_part >= (SW-HS)'(den_reg));

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial    = {1'b0, rem_reg, lo_reg[QB-1]} - {2'b00, den_reg};
    assign qbit     = ~trial[DW+1];
    assign rem_step = qbit ? trial[DW-1:0] : {rem_reg[DW-2:0], lo_reg[QB-1]};

    // negative sums round the magnitude up so the result is a floor
    assign tmag = {1'b0, q_reg} + (QB+1)'(neg_reg && (rem_reg != '0));

    always_comb
    begin
        dstate_next = dstate_reg;
        case (dstate_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    dstate_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                dstate_next = (den_zero || overflow) ? D_IDLE : D_STEP;
            end
            D_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    dstate_next = D_DONE;
                end
            end
            D_DONE:
            begin
                dstate_next = D_IDLE;
            end
            default:
            begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            done_reg   <= (dstate_reg == D_CHECK && (den_zero || overflow))
                          || (dstate_reg == D_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (dstate_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= sum[SW-1];
                    mag_reg <= sum[SW-1] ? (~sum + SW'(1)) : sum;
                    den_reg <= den;
                end
            end
            D_CHECK:
            begin
                if (den_zero)
                begin
                    sample_reg  <= '0;
                    clipped_reg <= 1'b0;
                end
                else if (overflow)
                begin
                    sample_reg  <= neg_reg ? wola_pkg::OUT_MIN : wola_pkg::OUT_MAX;
                    clipped_reg <= 1'b1;
                end
                rem_reg <= mag_reg[HS+DW-1:HS];
                lo_reg  <= {mag_reg[HS-1:0], wola_pkg::FRAC_SHIFT'(0)};
                cnt_reg <= wola_pkg::CNT_W'(QB - 1);
            end
            D_STEP:
            begin
                rem_reg <= rem_step;
                q_reg   <= {q_reg[QB-2:0], qbit};
                lo_reg  <= {lo_reg[QB-2:0], 1'b0};
                cnt_reg <= cnt_reg - wola_pkg::CNT_W'(1);
            end
            D_DONE:
            begin
                if (!neg_reg)
                begin
                    clipped_reg <= (tmag > wola_pkg::POS_LIMIT);
                    sample_reg  <= (tmag > wola_pkg::POS_LIMIT) ? wola_pkg::OUT_MAX
                                                                : tmag[QB-1:0];
                end
                else
                begin
                    clipped_reg <= (tmag > wola_pkg::NEG_LIMIT);
                    sample_reg  <= (tmag > wola_pkg::NEG_LIMIT) ? wola_pkg::OUT_MIN
                                                                : (~tmag[QB-1:0] + QB'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.done    = done_reg;
    assign res.sample  = sample_reg;
    assign res.clipped = clipped_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import wola_pkg::*;

    localparam int FRAME_LEN     = FRAME_LEN_DEF;
    localparam int ITEM_TARGET   = 1950;   // stimulus stops once this many items went in
    localparam int SETTLE_CYCLES = 40;     // idle wait after the owed results are in
    localparam int HOLD_CYCLES   = 400;    // long output back-pressure stretch

    localparam logic WIN_RECT    = 1'b0;
    localparam logic WIN_HAMMING = 1'b1;

    // one reconstructed output item as the predictor sees it
    typedef struct {
        logic [OUT_W-1:0] value;
        logic             clip;
        logic             uend;
    } wave_out_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;   // [31:0] frame_sample
    logic                  s_axis_tlast  = 1'b0; // final_frame
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // [15:0] out_sample
    logic                  m_axis_tuser;         // [0] clipped
    logic                  m_axis_tlast;         // utterance_end

    weighted_overlap_add_synthesis_core #(
        .FRAME_LEN(FRAME_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor copy of the block: accumulator rings, frame pointers, registers
    logic [SUM_W-1:0] acc_ring    [FRAME_LEN];
    logic [WT_W-1:0]  wsq_ring    [FRAME_LEN];
    logic [WIN_W-1:0] hamming_tab [FRAME_LEN];
    int unsigned      ring_start;
    int unsigned      frame_pos;
    logic             win_sel = WTYPE_RESET;
    logic [HOP_W-1:0] hop_reg = HOP_RESET;

    wave_out_t expected_out [$];   // reconstructed samples still owed by the block
    int        error_count = 0;
    int        items_sent  = 0;
    bit        no_idle     = 1'b0; // both sides run flat out while set
    bit        hold_req    = 1'b0; // asks the receiver for one long hold-off

    initial begin
        forever #5 clk = ~clk;
    end

    // hamming coefficient in q15, same fixed-point recipe as the window rom:
    // truncated taylor sine in q30, squared, scaled, rounded, capped at one
    function automatic logic [WIN_W-1:0] hamming_coeff(int unsigned i);
        logic [63:0] n1, j, phi, p2, t, s, s2, w;
        n1  = 64'(FRAME_LEN - 1);
        j   = (64'(2 * i) > n1) ? n1 - 64'(i) : 64'(i);  // fold onto the rising half
        phi = (j * PI_Q30) / n1;
        p2  = (phi * phi) >> 30;
        t   = Q30_ONE - p2 / 64'd110;
        t   = Q30_ONE - ((p2 * t) >> 30) / 64'd72;
        t   = Q30_ONE - ((p2 * t) >> 30) / 64'd42;
        t   = Q30_ONE - ((p2 * t) >> 30) / 64'd20;
        t   = Q30_ONE - ((p2 * t) >> 30) / 64'd6;
        s   = (phi * t) >> 30;
        s2  = (s * s) >> 30;
        w   = (WIN_A_Q30 + ((WIN_B_Q30 * s2) >> 30) + HALF_Q15) >> 15;
        return (w > 64'd32768) ? W_ONE_Q15 : w[WIN_W-1:0];
    endfunction

    // hop register as the block uses it: zero acts as one, above the frame as the frame
    function automatic int unsigned effective_hop();
        if (hop_reg == '0)
            return 1;
        if (int'(hop_reg) > FRAME_LEN)
            return FRAME_LEN;
        return int'(hop_reg);
    endfunction

    // floor(acc * 128 / den) with a 16-bit clamp; zero weight gives zero, no clip
    function automatic wave_out_t floor_divide_clamp(logic [SUM_W-1:0] acc,
                                                     logic [WT_W-1:0] den);
        wave_out_t        r;
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [63:0]      m, d, qm, rm, t;
        r.value = '0;
        r.clip  = 1'b0;
        r.uend  = 1'b0;
        neg = acc[SUM_W-1];
        mag = neg ? -acc : acc;
        m   = 64'(mag);
        d   = 64'(den);
        if (d == 64'd0)
            return r;
        qm = m / d;
        rm = m % d;
        if (qm >= 64'd65536) begin
            r.clip  = 1'b1;
            r.value = neg ? OUT_MIN : OUT_MAX;
            return r;
        end
        if (!neg) begin
            t = 64'd128 * qm + (64'd128 * rm) / d;
            if (t > 64'd32767) begin
                r.clip  = 1'b1;
                r.value = OUT_MAX;
            end
            else
                r.value = t[OUT_W-1:0];
        end
        else begin
            // floor of a negative quotient rounds the magnitude up
            t = 64'd128 * qm + (64'd128 * rm + d - 64'd1) / d;
            if (t > 64'd32768) begin
                r.clip  = 1'b1;
                r.value = OUT_MIN;
            end
            else begin
                t       = 64'd0 - t;
                r.value = t[OUT_W-1:0];
            end
        end
        return r;
    endfunction

    // one accepted frame sample: window, accumulate, emit finished slots, advance
    task automatic overlap_add_step(logic [SAMPLE_W-1:0] x, logic fin);
        int unsigned      fp, slot, hop;
        logic [WIN_W-1:0] w;
        logic [63:0]      xs, prod;
        wave_out_t        r;
        fp   = frame_pos % FRAME_LEN;
        slot = (ring_start + fp) % FRAME_LEN;
        hop  = effective_hop();
        w    = (win_sel == WIN_HAMMING) ? hamming_tab[fp] : W_ONE_Q15;
        xs   = {{32{x[SAMPLE_W-1]}}, x};
        prod = xs * {48'd0, w};
        acc_ring[slot] = acc_ring[slot] + prod[SUM_W-1:0];
        wsq_ring[slot] = wsq_ring[slot] + {24'd0, w} * {24'd0, w};
        // a slot is done once no later frame reaches it, or when the frame is final
        if (fin || fp < hop) begin
            r      = floor_divide_clamp(acc_ring[slot], wsq_ring[slot]);
            r.uend = fin && (fp == FRAME_LEN - 1);
            expected_out.push_back(r);
            acc_ring[slot] = '0;
            wsq_ring[slot] = '0;
        end
        // end of frame: shift by the hop, or back to slot zero after the last frame
        if (fp == FRAME_LEN - 1) begin
            ring_start = fin ? 0 : (ring_start + hop) % FRAME_LEN;
            frame_pos  = 0;
        end
        else
            frame_pos = fp + 1;
    endtask

    // idle lengths: mostly short, now and then a long one
    function automatic int gap_cycles();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // sample values: half in the unclipped band, some full range, some corners
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 32'h00FF_FFFE) - 32'h007F_FFFF;
        if (r < 80)
            return $urandom();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h007F_FF00;   // top of the 16-bit range with a rectangular window
            5: return 32'h0080_0000;
            6: return 32'hFF80_0000;   // bottom of the 16-bit range
            default: return 32'hFF7F_FFFF;
        endcase
    endfunction

    // offer one item, hold it until accepted, then predict its results
    task automatic send_sample(logic [SAMPLE_W-1:0] x, logic fin);
        int gap;
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            gap = gap_cycles();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        overlap_add_step(x, fin);
        items_sent++;
    endtask

    // random samples with a given share of final flags
    task automatic send_random_run(int count, int fin_pct);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(), $urandom_range(0, 99) < fin_pct);
    endtask

    // all owed results in, then a settle wait for an item that emits nothing
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both registers on back-to-back cycles, enable dropped after the second
    task automatic configure(logic wtype, logic [HOP_W-1:0] hop);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_WINDOW_TYPE;
        cfg_wdata <= CFG_DATA_W'(wtype);
        @(posedge clk);
        cfg_addr  <= REG_HOP_LENGTH;
        cfg_wdata <= hop;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        win_sel = wtype;
        hop_reg = hop;
    endtask

    // corner sample values and both flag values, first at reset settings, then rectangular
    task automatic test_field_extremes();
        logic [SAMPLE_W-1:0] corner [10] = '{
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h007F_FF00, 32'h0080_0000, 32'hFF7F_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
        };
        for (int round = 0; round < 2; round++) begin
            if (round == 1) begin
                wait_idle();
                configure(WIN_RECT, HOP_RESET);
            end
            for (int i = 0; i < 10; i++)
                send_sample(corner[i], (i % 3) == 2);
        end
    endtask

    // hop zero (acts as one) for the middle of the frame, then above the frame (acts as
    // the frame) for its tail, so the emit point moves inside one frame
    task automatic test_hop_change_mid_frame();
        wait_idle();
        configure(WIN_RECT, 10'd0);
        send_random_run(300 - int'(frame_pos), 0);
        wait_idle();
        configure(WIN_RECT, 10'd1023);
        send_random_run(FRAME_LEN - int'(frame_pos), 0);
    endtask

    // last frame with the final flag sometimes dropped, leftovers stay in the ring;
    // the receiver holds off for a long stretch so the block stalls its input
    task automatic test_dropped_final_flag();
        wait_idle();
        configure(WIN_HAMMING, 10'd128);
        hold_req = 1'b1;
        for (int i = int'(frame_pos); i < FRAME_LEN; i++)
            send_sample(pick_sample(), (i == FRAME_LEN - 1) || ($urandom_range(0, 9) != 0));
    endtask

    // utterances of random frames, settings changed between runs, mostly mid-frame
    task automatic test_random_utterances();
        int unsigned      run_len;
        logic [HOP_W-1:0] hop_pick;
        logic             in_final;
        logic             fin;
        in_final = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       hop_pick = 10'd0;
                1:       hop_pick = 10'd1;
                2:       hop_pick = 10'd512;
                3:       hop_pick = 10'd1023;
                4:       hop_pick = HOP_W'($urandom_range(513, 1022));
                5, 6:    hop_pick = HOP_W'($urandom_range(1, 16));
                default: hop_pick = HOP_W'($urandom_range(17, 511));
            endcase
            configure($urandom_range(0, 1) == 1, hop_pick);
            no_idle = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(60, 220);
            repeat (run_len) begin
                // decide at each frame start whether it closes the utterance
                if (frame_pos == 0)
                    in_final = ($urandom_range(0, 2) == 0);
                if (!in_final)
                    fin = ($urandom_range(0, 49) == 0);             // stray flag
                else if (frame_pos == FRAME_LEN - 1)
                    fin = ($urandom_range(0, 9) != 0);
                else
                    fin = ($urandom_range(0, 19) != 0);             // mostly set, some dropped
                send_sample(pick_sample(), fin);
            end
            no_idle = 1'b0;
        end
    endtask

    // receiver: random stalls, plus the long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = gap_cycles() - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result check against the oldest owed sample
    initial begin
        wave_out_t e;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected item: out_sample %0d", $signed(m_axis_tdata));
                    error_count++;
                end
                else begin
                    e = expected_out.pop_front();
                    if (m_axis_tdata !== e.value) begin
                        $error("out_sample: expected %0d, actual %0d",
                               $signed(e.value), $signed(m_axis_tdata));
                        error_count++;
                    end
                    if (m_axis_tuser !== e.clip) begin
                        $error("clipped: expected %0b, actual %0b", e.clip, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== e.uend) begin
                        $error("utterance_end: expected %0b, actual %0b", e.uend, m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            hamming_tab[i] = hamming_coeff(i);
            acc_ring[i]    = '0;
            wsq_ring[i]    = '0;
        end
        ring_start = 0;
        frame_pos  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // the ring clearing pass after reset shows as tready low, send waits it out
        test_field_extremes();
        test_hop_change_mid_frame();
        test_dropped_final_flag();
        test_random_utterances();
        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
